>>> sv/mie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_pkg - shared types for the modular inverse block
// Operation codes of the shared arithmetic unit and the status bundle that
// the sequencer reports to the top level.
// ----------------------------------------------------------------------------
package mie_pkg;

  // operation of the coefficient lane of the shared unit
  typedef enum logic {
    COEF_SUB = 1'b0,
    COEF_ADD = 1'b1
  } coef_op_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic busy;
    logic res_valid;
  } core_stat_t;

endpackage

>>> sv/mie_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_alu - shared compare / subtract unit
// One unsigned remainder lane (difference and greater-or-equal flag) and one
// signed coefficient lane (add or subtract), used by every arithmetic step of the
// sequencer.
// ----------------------------------------------------------------------------
module mie_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH:0]        a,
  input  logic [DATA_WIDTH:0]        b,
  input  logic signed [DATA_WIDTH:0] ca,
  input  logic signed [DATA_WIDTH:0] cb,
  input  mie_pkg::coef_op_t          cop,
  output logic [DATA_WIDTH:0]        diff,
  output logic                       ge,
  output logic signed [DATA_WIDTH:0] cres
);

  assign diff = a - b;
  assign ge   = (a >= b);

  always_comb begin
    case (cop)
      mie_pkg::COEF_ADD: cres = ca + cb;
      mie_pkg::COEF_SUB: cres = ca - cb;
      default:           cres = ca - cb;
    endcase
  end

endmodule

>>> sv/mie_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_core - extended Euclid sequencer
// Reduces the input modulo p, then runs remainder / coefficient updates by
// shift-and-subtract division on the shared unit until the remainder is zero.
// ----------------------------------------------------------------------------
module mie_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DATA_WIDTH-1:0]   value,
  input  logic [DATA_WIDTH-2:0]   modulus,
  input  logic                    res_take,
  output mie_pkg::core_stat_t     stat,
  output logic [DATA_WIDTH-2:0]   result
);

  localparam int W  = DATA_WIDTH;
  localparam int KW = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_ALIGN,
    ST_SUB,
    ST_RFIX,
    ST_STEP,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [W-1:0]         r0_r;
  logic [W-1:0]         r1_r;
  logic [W:0]           d_r;
  logic signed [W:0]    c0_r;
  logic signed [W:0]    c1_r;
  logic signed [W:0]    e_r;
  logic [KW-1:0]        k_r;
  logic [W-2:0]         p_r;
  logic                 neg_r;
  logic                 red_r;

  logic [W:0]           alu_a;
  logic [W:0]           alu_b;
  logic signed [W:0]    alu_ca;
  logic signed [W:0]    alu_cb;
  mie_pkg::coef_op_t    alu_cop;
  logic [W:0]           alu_diff;
  logic                 alu_ge;
  logic signed [W:0]    alu_cres;
  logic [W-1:0]         rem;

  always_comb begin
    alu_a   = {1'b0, r0_r};
    alu_b   = d_r;
    alu_ca  = c0_r;
    alu_cb  = e_r;
    alu_cop = mie_pkg::COEF_SUB;
    case (state_r)
      ST_ABS: begin
        alu_a = '0;
        alu_b = {1'b0, r0_r};
      end
      ST_ALIGN: begin
        alu_b = {d_r[W-1:0], 1'b0};
      end
      ST_RFIX: begin
        alu_a = {2'b00, p_r};
        alu_b = {1'b0, r0_r};
      end
      ST_FIN: begin
        alu_cb  = $signed({2'b00, p_r});
        alu_cop = mie_pkg::COEF_ADD;
      end
      default: begin
        alu_a = {1'b0, r0_r};
      end
    endcase
  end

  mie_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .ca   (alu_ca),
    .cb   (alu_cb),
    .cop  (alu_cop),
    .diff (alu_diff),
    .ge   (alu_ge),
    .cres (alu_cres)
  );

  // truncating remainder of a negative value: fold back into [0,p)
  assign rem = (neg_r && (r0_r != '0)) ? alu_diff[W-1:0] : r0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            p_r   <= modulus;
            r0_r  <= value;
            neg_r <= value[W-1];
            d_r   <= {2'b00, modulus};
            e_r   <= '0;
            c0_r  <= '0;
            k_r   <= '0;
            red_r <= 1'b1;
            state_r <= (modulus == '0) ? ST_FIN : ST_ABS;
          end
        end
        ST_ABS: begin
          if (neg_r) begin
            r0_r <= alu_diff[W-1:0];
          end
          state_r <= ST_ALIGN;
        end
        ST_ALIGN: begin
          // raise divisor while twice it still fits under the remainder
          if (alu_ge) begin
            d_r <= {d_r[W-1:0], 1'b0};
            e_r <= e_r <<< 1;
            k_r <= k_r + 1'b1;
          end else begin
            state_r <= ST_SUB;
          end
        end
        ST_SUB: begin
          if (alu_ge) begin
            r0_r <= alu_diff[W-1:0];
            c0_r <= alu_cres;
          end
          if (k_r == '0) begin
            state_r <= red_r ? ST_RFIX : ST_STEP;
          end else begin
            d_r <= d_r >> 1;
            e_r <= e_r >>> 1;
            k_r <= k_r - 1'b1;
          end
        end
        ST_RFIX: begin
          red_r <= 1'b0;
          r0_r  <= {1'b0, p_r};
          r1_r  <= rem;
          c0_r  <= '0;
          c1_r  <= $signed({{W{1'b0}}, 1'b1});
          d_r   <= {1'b0, rem};
          e_r   <= $signed({{W{1'b0}}, 1'b1});
          k_r   <= '0;
          state_r <= (rem == '0) ? ST_FIN : ST_ALIGN;
        end
        ST_STEP: begin
          // swap: old r1 becomes r0, the new remainder becomes r1
          r0_r <= r1_r;
          r1_r <= r0_r;
          c0_r <= c1_r;
          c1_r <= c0_r;
          d_r  <= {1'b0, r0_r};
          e_r  <= c0_r;
          k_r  <= '0;
          state_r <= (r0_r == '0) ? ST_FIN : ST_ALIGN;
        end
        ST_FIN: begin
          if (c0_r[W]) begin
            c0_r <= alu_cres;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat.busy      = (state_r != ST_IDLE);
  assign stat.res_valid = (state_r == ST_DONE);
  assign result         = c0_r[W-2:0];

endmodule

>>> sv/modular_inverse_ext_euclid_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_top - modular inverse by extended Euclid
// Returns the inverse of a signed value modulo the configured modulus.
// ----------------------------------------------------------------------------
// One item at a time: in_stall is high from acceptance until the result has
// moved into the output register. All work runs on one shared compare /
// subtract unit by shift-and-subtract division. The input is first reduced
// modulo p by dividing |value| by p, then each Euclid step divides by the
// current remainder, and a final step folds a negative coefficient into
// [0,p). The result waits in an output register, so the next item is taken
// while it stalls. Modulus 0 or 1 and inputs congruent to zero give 0.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [DATA_WIDTH-2:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-2:0] out_inverse
);

  logic [DATA_WIDTH-2:0] mod_r;
  logic                  out_valid_r;
  logic [DATA_WIDTH-2:0] out_inverse_r;
  mie_pkg::core_stat_t   stat;
  logic [DATA_WIDTH-2:0] core_result;
  logic                  start;
  logic                  res_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= {{(DATA_WIDTH-3){1'b0}}, 2'b10};
    end else if (cfg_wr_en) begin
      mod_r <= cfg_wr_data;
    end
  end

  assign in_stall = stat.busy;
  assign start    = in_valid && !stat.busy;
  // move the result on when the output register is empty or being emptied
  assign res_take = stat.res_valid && (!out_valid_r || !out_stall);

  mie_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .value    (in_value),
    .modulus  (mod_r),
    .res_take (res_take),
    .stat     (stat),
    .result   (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_inverse_r <= core_result;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_inverse = out_inverse_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("sequencer not busy after an accepted item");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_valid && !res_take |=> stat.res_valid)
    else $error("finished result dropped before it was moved");

  a_take_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid_r && !stat.res_valid)
    else $error("result move did not fill the output register");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - modular inverse by extended Euclid
// A queue-fed driver and a stalling receiver run the block through several
// modulus settings and idle mixes. Every result is checked against a local
// computation of the inverse that uses the modulus in effect when its item
// was accepted.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DW             = 32;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int QUIET_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 52;
  localparam int HEAVY_IDLE_PCT = 87;
  localparam int LIGHT_IDLE_PCT = 12;

  localparam logic [DW-2:0] MOD_RESET     = 31'd2;
  localparam logic [DW-2:0] MOD_MAX       = 31'h7FFF_FFFF;
  localparam logic [DW-2:0] MOD_ZERO      = 31'd0;
  localparam logic [DW-2:0] MOD_ONE       = 31'd1;
  localparam logic [DW-2:0] MOD_COMPOSITE = 31'd1000000;

  logic          clk         = 1'b0;
  logic          rst_n       = 1'b0;
  logic          cfg_wr_en   = 1'b0;
  logic [DW-2:0] cfg_wr_data = '0;
  logic          in_valid    = 1'b0;
  logic          in_stall;
  logic [DW-1:0] in_value    = '0;
  logic          out_valid;
  logic          out_stall   = 1'b0;
  logic [DW-2:0] out_inverse;

  logic [DW-1:0] pending_values[$];
  logic [DW-2:0] inverse_q[$];
  logic [DW-2:0] modulus_now = MOD_RESET;

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int settings_used   = 1;
  int quiet           = 0;

  logic [DW-1:0] at_reset_values[6] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd3,
                                        32'h8000_0000, 32'h7FFF_FFFF};
  logic [DW-1:0] at_max_values[11] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2,
                                       32'hFFFF_FFFE, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFE,
                                       32'h5555_5555, 32'hAAAA_AAAA,
                                       32'd1234567};
  logic [DW-1:0] at_zero_values[3] = '{32'd5, 32'hFFFF_FFF9, 32'd0};
  logic [DW-1:0] at_one_values[3] = '{32'd0, 32'd9, 32'h8000_0000};
  logic [DW-1:0] at_composite_values[4] = '{32'd2, 32'd3, 32'd500000,
                                            32'hFFF0_BDC0};
  logic [DW-2:0] prime_moduli[11] = '{31'd2, 31'd3, 31'd5, 31'd7, 31'd251,
                                      31'd65521, 31'd65537, 31'd1000003,
                                      31'd1073741789, 31'd2147483629,
                                      31'h7FFF_FFFF};

  always #(HALF_PERIOD) clk = ~clk;

  modular_inverse_ext_euclid_top #(
    .DATA_WIDTH (DW)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_inverse (out_inverse)
  );

  // Extended Euclid on 64-bit integers; truncating division as in hardware.
  function automatic logic [DW-2:0] inverse_of(logic [DW-1:0] raw,
                                               logic [DW-2:0] modulus);
    longint v, p, r_prev, r_cur, c_prev, c_cur, quo, tmp;
    v = longint'($signed(raw));
    p = longint'(modulus);
    if (p <= 0) return '0;
    r_prev = p;
    r_cur  = v % p;
    if (r_cur < 0) r_cur += p;
    c_prev = 0;
    c_cur  = 1;
    while (r_cur != 0) begin
      quo    = r_prev / r_cur;
      tmp    = r_prev - quo * r_cur;
      r_prev = r_cur;
      r_cur  = tmp;
      tmp    = c_prev - quo * c_cur;
      c_prev = c_cur;
      c_cur  = tmp;
    end
    if (c_prev < 0) c_prev += p;
    return c_prev[DW-2:0];
  endfunction

  function automatic logic [DW-1:0] pick_value(logic [DW-2:0] modulus);
    int     kind;
    longint near_multiple;
    kind = $urandom_range(99);
    if (kind < 50) return $urandom;
    if (kind < 70) return $urandom_range(2000) - 1000;
    if (kind < 90) begin
      // land on or next to a multiple of p, either sign
      near_multiple = longint'(modulus) * longint'($urandom_range(4))
                      + longint'($urandom_range(2)) - 1;
      if ($urandom_range(1) == 1) near_multiple = -near_multiple;
      return near_multiple[DW-1:0];
    end
    case ($urandom_range(3))
      0:       return '0;
      1:       return {1'b0, {(DW-1){1'b1}}};
      2:       return {1'b1, {(DW-1){1'b0}}};
      default: return '1;
    endcase
  endfunction

  function automatic logic [DW-2:0] pick_modulus();
    case ($urandom_range(3))
      1:       return (DW-1)'($urandom);
      2:       return (DW-1)'($urandom_range(300, 2));
      default: return prime_moduli[$urandom_range(10)];
    endcase
  endfunction

  // wait until every item has been sent and every inverse has come back
  task automatic drain();
    @(negedge clk);
    while (pending_values.size() != 0 || in_valid || inverse_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_modulus(logic [DW-2:0] modulus);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= modulus;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    modulus_now = modulus;
    settings_used++;
  endtask

  // driver: advance to the next item only when the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_value <= pending_values.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      inverse_q.push_back(inverse_of(in_value, modulus_now));
      items_sent++;
    end
  end

  always @(posedge clk) begin : check_results
    logic [DW-2:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (inverse_q.size() == 0) begin
          $error("inverse: result %0d with no item outstanding", out_inverse);
          errors++;
        end else begin
          want = inverse_q.pop_front();
          results_checked++;
          if (out_inverse !== want) begin
            $error("inverse: expected %0d, actual %0d", want, out_inverse);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (at_reset_values[i]) pending_values.push_back(at_reset_values[i]);
    drain();
    set_modulus(MOD_MAX);
    foreach (at_max_values[i]) pending_values.push_back(at_max_values[i]);
    drain();
    set_modulus(MOD_ZERO);
    foreach (at_zero_values[i]) pending_values.push_back(at_zero_values[i]);
    drain();
    set_modulus(MOD_ONE);
    foreach (at_one_values[i]) pending_values.push_back(at_one_values[i]);
    drain();
    set_modulus(MOD_COMPOSITE);
    foreach (at_composite_values[i])
      pending_values.push_back(at_composite_values[i]);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;              recv_stall_pct = 0;              end
        1: begin send_idle_pct = HEAVY_IDLE_PCT; recv_stall_pct = 0;              end
        2: begin send_idle_pct = 0;              recv_stall_pct = HEAVY_IDLE_PCT; end
        default: begin
          send_idle_pct  = LIGHT_IDLE_PCT;
          recv_stall_pct = LIGHT_IDLE_PCT;
        end
      endcase
      set_modulus(pick_modulus());
      for (int k = 0; k < PHASE_ITEMS; k++)
        pending_values.push_back(pick_value(modulus_now));
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d inverses from %0d items across %0d modulus settings",
             results_checked, items_sent, settings_used);
    $display("moduli included reset value, 0, 1, a composite and the 31-bit max");
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
